### hdl/cgws_pkg.sv
// ----------------------------------------------------------------------------
// cgws_pkg
// Shared widths, constants and the month table for the calendar to GPS
// week and second converter.
// ----------------------------------------------------------------------------
package cgws_pkg;

    localparam int YEAR_W        = 12;
    localparam int MONTH_W       = 4;
    localparam int MDAY_W        = 5;
    localparam int HOUR_W        = 5;
    localparam int MINUTE_W      = 6;
    localparam int SECOND_W      = 6;
    localparam int FRAC_W        = 20;
    localparam int WEEK_W        = 14;
    localparam int SOW_W         = 20;

    localparam int FRACTION_BITS_DEF = 20;

    localparam int DAYS_W        = 20;
    localparam int PROD_W        = 41;
    localparam int QUOT_LSB      = 23;
    localparam int TOD_W         = 17;
    localparam int MDAYS_W       = 9;

    localparam logic [20:0] DIV7_RECIP      = 21'd1198373;
    localparam logic [16:0] SECONDS_PER_DAY = 17'd86400;

    typedef logic [DAYS_W-1:0] t_days;
    typedef logic [PROD_W-1:0] t_prod;
    typedef logic [TOD_W-1:0]  t_tod;

    // Month term of the day count, the integer part of 30.6001 times the month
    // plus one, with months below three taken as months 12 to 14 of the prior year.
    function automatic logic [MDAYS_W-1:0] month_days(input logic [MONTH_W-1:0] month);
        logic [MDAYS_W-1:0] md;
        case (month)
            4'd0:    md = 9'd397;
            4'd1:    md = 9'd428;
            4'd2:    md = 9'd459;
            4'd3:    md = 9'd122;
            4'd4:    md = 9'd153;
            4'd5:    md = 9'd183;
            4'd6:    md = 9'd214;
            4'd7:    md = 9'd244;
            4'd8:    md = 9'd275;
            4'd9:    md = 9'd306;
            4'd10:   md = 9'd336;
            4'd11:   md = 9'd367;
            4'd12:   md = 9'd397;
            4'd13:   md = 9'd428;
            4'd14:   md = 9'd459;
            default: md = 9'd489;
        endcase
        return md;
    endfunction

endpackage

### hdl/cgws_week_split.sv
// ----------------------------------------------------------------------------
// cgws_week_split
// Splits a day count into GPS week and day of week using the registered
// reciprocal product, and forms the seconds of week.
// ----------------------------------------------------------------------------
module cgws_week_split (
    input  cgws_pkg::t_prod                 i_prod,
    input  cgws_pkg::t_days                 i_days,
    input  cgws_pkg::t_tod                  i_tod,
    input  logic                            i_before,
    output logic [cgws_pkg::WEEK_W-1:0]     o_week,
    output logic [cgws_pkg::SOW_W-1:0]      o_sow
);
    import cgws_pkg::*;

    localparam int QUOT_W = PROD_W - QUOT_LSB;

    logic [QUOT_W-1:0] quot;
    logic [DAYS_W-1:0] seven_q;
    logic [2:0]        dow;
    logic [SOW_W-1:0]  sow;

    always_comb begin
        quot    = i_prod[PROD_W-1:QUOT_LSB];
        seven_q = DAYS_W'({quot, 2'b00}) + DAYS_W'({quot, 1'b0}) + DAYS_W'(quot);
        dow     = 3'(i_days - seven_q);
        sow     = SOW_W'(SOW_W'(dow) * SOW_W'(SECONDS_PER_DAY)) + SOW_W'(i_tod);
        if (i_before) begin
            o_week = '0;
            o_sow  = '0;
        end else begin
            o_week = quot[WEEK_W-1:0];
            o_sow  = sow;
        end
    end

endmodule

### hdl/calendar_to_gps_week_second_top.sv
// ----------------------------------------------------------------------------
// calendar_to_gps_week_second_top
// Converts a Gregorian date and time of day into GPS week, seconds of week
// and the passed-through sub-second fraction.
//
// The block accepts one transaction per clock while o_ready is high, and
// results leave through a five-stage pipeline: input registration and month
// lookup, year and century terms, day count against the GPS epoch, the
// reciprocal multiply for division by seven, and the week split. A stall on
// the output holds only the stages that are occupied, so bubbles are
// squeezed out. Dates before 6 January 1980 raise before_epoch with week and
// seconds forced to zero. No leap-second correction is applied.
// ----------------------------------------------------------------------------
module calendar_to_gps_week_second_top #(
    parameter int FRACTION_BITS = cgws_pkg::FRACTION_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [cgws_pkg::YEAR_W-1:0]        i_year,
    input  logic [cgws_pkg::MONTH_W-1:0]       i_month,
    input  logic [cgws_pkg::MDAY_W-1:0]        i_day_of_month,
    input  logic [cgws_pkg::HOUR_W-1:0]        i_hour,
    input  logic [cgws_pkg::MINUTE_W-1:0]      i_minute,
    input  logic [cgws_pkg::SECOND_W-1:0]      i_whole_second,
    input  logic [cgws_pkg::FRAC_W-1:0]        i_sub_second,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [cgws_pkg::WEEK_W-1:0]        o_gps_week,
    output logic [cgws_pkg::SOW_W-1:0]         o_week_seconds,
    output logic [cgws_pkg::FRAC_W-1:0]        o_week_fraction,
    output logic                               o_before_epoch
);
    import cgws_pkg::*;

    localparam int FRAC_KEEP = (FRACTION_BITS < FRAC_W) ? FRACTION_BITS : FRAC_W;
    localparam int NSTAGE    = 5;

    logic [NSTAGE-1:0] r_v;
    logic [NSTAGE-1:0] n_v;
    logic [NSTAGE-1:0] en;

    logic [FRAC_KEEP-1:0] r_frac0, r_frac1, r_frac2, r_frac3, r_frac4;
    t_tod                 r_tod0, r_tod1, r_tod2, r_tod3;

    logic signed [12:0]   r_y0;
    logic [MDAYS_W-1:0]   r_md0;
    logic [MDAY_W-1:0]    r_mday0;

    logic signed [21:0]   r_yd1;
    logic [5:0]           r_a1;
    logic [9:0]           r_sum1;

    t_days                r_days2;
    logic                 r_before2;

    t_prod                r_prod3;
    t_days                r_days3;
    logic                 r_before3;

    logic [WEEK_W-1:0]    r_week4;
    logic [SOW_W-1:0]     r_sow4;
    logic                 r_before4;

    logic                 shift;
    logic signed [12:0]   y_in;
    t_tod                 tod_in;
    logic signed [24:0]   yd_full;
    logic [11:0]          y_pos;
    logic [24:0]          a_prod;
    logic signed [22:0]   days_full;
    t_prod                prod;
    logic [WEEK_W-1:0]    week;
    logic [SOW_W-1:0]     sow;

    always_comb begin
        en[4] = !r_v[4] || i_ready;
        en[3] = !r_v[3] || en[4];
        en[2] = !r_v[2] || en[3];
        en[1] = !r_v[1] || en[2];
        en[0] = !r_v[0] || en[1];
        n_v[0] = en[0] ? i_valid : r_v[0];
        n_v[1] = en[1] ? r_v[0]  : r_v[1];
        n_v[2] = en[2] ? r_v[1]  : r_v[2];
        n_v[3] = en[3] ? r_v[2]  : r_v[3];
        n_v[4] = en[4] ? r_v[3]  : r_v[4];
    end

    assign o_ready = en[0];

    always_comb begin
        shift  = (i_month < MONTH_W'(3));
        y_in   = $signed({1'b0, i_year}) - $signed({12'd0, shift});
        tod_in = TOD_W'(TOD_W'(i_hour) * TOD_W'(3600)) + TOD_W'(TOD_W'(i_minute) * TOD_W'(60))
               + TOD_W'(i_whole_second);
    end

    always_comb begin
        yd_full = 25'(r_y0) * $signed(25'd1461);
        y_pos   = r_y0[12] ? 12'd0 : r_y0[11:0];
        a_prod  = 25'(y_pos) * 25'd5243;
    end

    always_comb begin
        days_full = 23'(r_yd1) + $signed(23'(r_sum1)) + $signed(23'd2) - $signed(23'(r_a1))
                  + $signed(23'(r_a1[5:2])) - $signed(23'd723250);
    end

    assign prod = PROD_W'(r_days2) * PROD_W'(DIV7_RECIP);

    cgws_week_split u_week_split (
        .i_prod   (r_prod3),
        .i_days   (r_days3),
        .i_tod    (r_tod3),
        .i_before (r_before3),
        .o_week   (week),
        .o_sow    (sow)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_y0    <= y_in;
            r_md0   <= month_days(i_month);
            r_mday0 <= i_day_of_month;
            r_tod0  <= tod_in;
            r_frac0 <= i_sub_second[FRAC_KEEP-1:0];
        end
        if (en[1]) begin
            r_yd1   <= 22'(yd_full >>> 2);
            r_a1    <= a_prod[24:19];
            r_sum1  <= 10'(r_md0) + 10'(r_mday0);
            r_tod1  <= r_tod0;
            r_frac1 <= r_frac0;
        end
        if (en[2]) begin
            r_days2   <= days_full[DAYS_W-1:0];
            r_before2 <= days_full[22];
            r_tod2    <= r_tod1;
            r_frac2   <= r_frac1;
        end
        if (en[3]) begin
            r_prod3   <= prod;
            r_days3   <= r_days2;
            r_before3 <= r_before2;
            r_tod3    <= r_tod2;
            r_frac3   <= r_frac2;
        end
        if (en[4]) begin
            r_week4   <= week;
            r_sow4    <= sow;
            r_before4 <= r_before3;
            r_frac4   <= r_frac3;
        end
    end

    assign o_valid         = r_v[4];
    assign o_gps_week      = r_week4;
    assign o_week_seconds  = r_sow4;
    assign o_week_fraction = FRAC_W'(r_frac4);
    assign o_before_epoch  = r_before4;

    // A result before the epoch never carries a week or seconds value.
    a_before_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_before_epoch |-> o_gps_week == '0 && o_week_seconds == '0)
        else $error("before_epoch result with nonzero week or seconds");

    // The day of week stays below seven, so seconds stay within the bound.
    a_sow_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_week_seconds < SOW_W'(633844))
        else $error("week_seconds out of range");

    // Input back-pressure only arises from a stalled, occupied output stage.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready && r_v == '1)
        else $error("input stalled without a full stalled pipeline");

endmodule

### sim/tb_calendar_to_gps_week_second_top.sv
// ----------------------------------------------------------------------------
// tb_calendar_to_gps_week_second_top
// Self-checking testbench for the calendar to GPS week and second converter.
// Directed dates cover the epoch edge, field extremes, every month code and
// the leap second. Random dates follow, mostly well-formed, with noise, under
// several sender idle and receiver stall mixes. A monitor predicts each
// accepted transaction and compares every returned result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_calendar_to_gps_week_second_top;

    import cgws_pkg::*;

    localparam int  FRACTION_BITS = FRACTION_BITS_DEF;
    localparam int  EPOCH_OFFSET  = 723250;
    localparam int  CYCLE_LIMIT   = 200000;
    localparam int  DRAIN_CYCLES  = 20;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [MDAY_W-1:0]   day_of_month;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] whole_second;
        logic [FRAC_W-1:0]   sub_second;
    } t_date_item;

    typedef struct packed {
        logic [WEEK_W-1:0] gps_week;
        logic [SOW_W-1:0]  week_seconds;
        logic [FRAC_W-1:0] week_fraction;
        logic              before_epoch;
    } t_gps_time;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [YEAR_W-1:0]   i_year;
    logic [MONTH_W-1:0]  i_month;
    logic [MDAY_W-1:0]   i_day_of_month;
    logic [HOUR_W-1:0]   i_hour;
    logic [MINUTE_W-1:0] i_minute;
    logic [SECOND_W-1:0] i_whole_second;
    logic [FRAC_W-1:0]   i_sub_second;
    logic                o_valid;
    logic                i_ready;
    logic [WEEK_W-1:0]   o_gps_week;
    logic [SOW_W-1:0]    o_week_seconds;
    logic [FRAC_W-1:0]   o_week_fraction;
    logic                o_before_epoch;

    t_gps_time gps_expected[$];
    t_gps_time gps_want;
    int        mismatch_count;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_stall_pct;

    calendar_to_gps_week_second_top #(
        .FRACTION_BITS(FRACTION_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_year         (i_year),
        .i_month        (i_month),
        .i_day_of_month (i_day_of_month),
        .i_hour         (i_hour),
        .i_minute       (i_minute),
        .i_whole_second (i_whole_second),
        .i_sub_second   (i_sub_second),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_gps_week     (o_gps_week),
        .o_week_seconds (o_week_seconds),
        .o_week_fraction(o_week_fraction),
        .o_before_epoch (o_before_epoch)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_gps_time to_gps_time(input t_date_item d);
        longint    yr;
        longint    mo;
        longint    cent;
        longint    prod;
        longint    year_part;
        longint    dcount;
        longint    sow;
        longint    frac_mask;
        t_gps_time r;
        yr = d.year;
        mo = d.month;
        if (mo < 3) begin
            yr = yr - 1;
            mo = mo + 12;
        end
        cent = yr / 100;
        prod = 1461 * yr;
        if (prod >= 0) begin
            year_part = prod / 4;
        end else begin
            year_part = -((-prod + 3) / 4);
        end
        dcount = year_part + (306001 * (mo + 1)) / 10000 + longint'(d.day_of_month)
                 + (2 - cent + cent / 4) - EPOCH_OFFSET;
        frac_mask = (longint'(1) << FRACTION_BITS) - 1;
        r.week_fraction = FRAC_W'(longint'(d.sub_second) & frac_mask);
        if (dcount < 0) begin
            r.gps_week     = '0;
            r.week_seconds = '0;
            r.before_epoch = 1'b1;
        end else begin
            sow = (dcount % 7) * 86400 + longint'(d.hour) * 3600
                  + longint'(d.minute) * 60 + longint'(d.whole_second);
            r.gps_week     = WEEK_W'(dcount / 7);
            r.week_seconds = SOW_W'(sow);
            r.before_epoch = 1'b0;
        end
        return r;
    endfunction

    function automatic t_date_item make_date(input int yr, input int mo, input int md,
                                             input int hr, input int mi, input int sc,
                                             input int fr);
        t_date_item d;
        d.year         = YEAR_W'(yr);
        d.month        = MONTH_W'(mo);
        d.day_of_month = MDAY_W'(md);
        d.hour         = HOUR_W'(hr);
        d.minute       = MINUTE_W'(mi);
        d.whole_second = SECOND_W'(sc);
        d.sub_second   = FRAC_W'(fr);
        return d;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        mismatch_count++;
    endtask

    task automatic send_date(input t_date_item d);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid        = 1'b1;
        i_year         = d.year;
        i_month        = d.month;
        i_day_of_month = d.day_of_month;
        i_hour         = d.hour;
        i_minute       = d.minute;
        i_whole_second = d.whole_second;
        i_sub_second   = d.sub_second;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                gps_expected.push_back(to_gps_time({i_year, i_month, i_day_of_month,
                                                    i_hour, i_minute, i_whole_second,
                                                    i_sub_second}));
            end
            if (o_valid && i_ready) begin
                if (gps_expected.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    gps_want = gps_expected.pop_front();
                    if (o_gps_week !== gps_want.gps_week)
                        report_mismatch("gps_week", int'(o_gps_week),
                                        int'(gps_want.gps_week));
                    if (o_week_seconds !== gps_want.week_seconds)
                        report_mismatch("week_seconds", int'(o_week_seconds),
                                        int'(gps_want.week_seconds));
                    if (o_week_fraction !== gps_want.week_fraction)
                        report_mismatch("week_fraction", int'(o_week_fraction),
                                        int'(gps_want.week_fraction));
                    if (o_before_epoch !== gps_want.before_epoch)
                        report_mismatch("before_epoch", int'(o_before_epoch),
                                        int'(gps_want.before_epoch));
                end
            end
        end
    end

    task automatic test_epoch_edges();
        send_date(make_date(1980, 1, 6, 0, 0, 0, 0));
        send_date(make_date(1980, 1, 5, 23, 59, 60, 1048575));
        send_date(make_date(1980, 1, 13, 0, 0, 0, 1));
    endtask

    task automatic test_field_extremes();
        send_date(make_date(0, 1, 0, 0, 0, 0, 0));
        send_date(make_date(0, 0, 0, 0, 0, 0, 0));
        send_date(make_date(4095, 15, 31, 31, 63, 63, 1048575));
        send_date(make_date(2235, 12, 31, 23, 59, 59, 699050));
        send_date(make_date(2158, 1, 2, 31, 63, 63, 349525));
    endtask

    task automatic test_month_shift();
        for (int mo = 0; mo < 16; mo++) begin
            send_date(make_date(2000, mo, 15, 12, 30, 30, mo * 65536));
        end
    endtask

    task automatic test_leap_second();
        send_date(make_date(2016, 12, 31, 23, 59, 60, 524288));
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        t_date_item  d;
        int          kind;
        logic [95:0] noise;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                d = make_date($urandom_range(1980, 2235), $urandom_range(1, 12),
                              $urandom_range(1, 31), $urandom_range(0, 23),
                              $urandom_range(0, 59), $urandom_range(0, 60),
                              $urandom_range(0, 1048575));
            end else if (kind < 80) begin
                d = make_date($urandom_range(1979, 1980), $urandom_range(0, 2),
                              $urandom_range(1, 12), $urandom_range(0, 23),
                              $urandom_range(0, 59), $urandom_range(0, 60),
                              $urandom_range(0, 1048575));
            end else begin
                noise = {$urandom, $urandom, $urandom};
                d     = noise[$bits(t_date_item)-1:0];
            end
            send_date(d);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_year         = '0;
        i_month        = '0;
        i_day_of_month = '0;
        i_hour         = '0;
        i_minute       = '0;
        i_whole_second = '0;
        i_sub_second   = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_epoch_edges();
        test_field_extremes();
        test_month_shift();
        test_leap_second();
        test_random_traffic(0, 0, 380);
        test_random_traffic(71, 0, 380);
        test_random_traffic(0, 71, 380);
        test_random_traffic(28, 28, 380);

        @(negedge i_clk);
        i_valid = 1'b0;
        while (gps_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
